// ===== rtl/gei_pkg.sv =====
// ----------------------------------------------------------------------------
// gei_pkg: shared types, codes and helpers of the gravity Euler integrator
// Field widths, item kind codes and the saturating arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package gei_pkg;

  localparam int unsigned WORD_W = 48;
  localparam int unsigned MASS_W = 32;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned KIND_W = 2;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam kind_t KIND_LOAD = 2'd0;
  localparam kind_t KIND_ATTR = 2'd1;
  localparam kind_t KIND_STEP = 2'd2;
  localparam kind_t KIND_RSVD = 2'd3;

  localparam logic [WORD_W-1:0] GRAV_RESET = 48'h0100_0000_0000;
  localparam word_t SMAX = 48'sh7FFF_FFFF_FFFF;
  localparam word_t SMIN = 48'sh8000_0000_0000;

  // Clamp a 58-bit signed value into the 48-bit range.
  function automatic word_t sat48(input logic signed [57:0] v);
    word_t r;
    if (v > 58'sh000_7FFF_FFFF_FFFF) r = SMAX;
    else if (v < -58'sh000_8000_0000_0000) r = SMIN;
    else r = v[47:0];
    return r;
  endfunction

  // Magnitude of a 48-bit signed value; the most negative value fits as 2^47.
  function automatic logic [47:0] mag48(input word_t v);
    logic [47:0] r;
    r = v[47] ? 48'(-v) : 48'(v);
    return r;
  endfunction

  // base + (neg ? -m : m), saturated.
  function automatic word_t add_sat(input word_t base, input logic [55:0] m,
                                    input logic neg);
    logic signed [57:0] t;
    logic signed [57:0] b;
    t = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
    b = 58'(base);
    return sat48(b + t);
  endfunction

  // Signed, saturated pull from an unsigned 81-bit magnitude.
  function automatic word_t pull_sat(input logic [80:0] p, input logic neg);
    word_t r;
    if (|p[80:47]) r = neg ? SMIN : SMAX;
    else r = neg ? -$signed(p[47:0]) : $signed(p[47:0]);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gei_in_if.sv =====
// ----------------------------------------------------------------------------
// gei_in_if: input item channel
// Valid/ready channel carrying one body, attractor or time step item.
// ----------------------------------------------------------------------------
`default_nettype none

interface gei_in_if
  import gei_pkg::*;
;
  logic                     valid;
  logic                     ready;
  kind_t                    kind;
  logic signed [WORD_W-1:0] pos_x;
  logic signed [WORD_W-1:0] pos_y;
  logic signed [WORD_W-1:0] vel_in_x;
  logic signed [WORD_W-1:0] vel_in_y;
  logic [MASS_W-1:0]        body_mass;
  logic [TIME_W-1:0]        step_time;

  modport source (output valid, kind, pos_x, pos_y, vel_in_x, vel_in_y, body_mass,
                  step_time, input ready);
  modport sink (input valid, kind, pos_x, pos_y, vel_in_x, vel_in_y, body_mass,
                step_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/gei_out_if.sv =====
// ----------------------------------------------------------------------------
// gei_out_if: result item channel
// Valid/ready channel carrying the pull and the body state after one item.
// ----------------------------------------------------------------------------
`default_nettype none

interface gei_out_if
  import gei_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] acc_x;
  logic signed [WORD_W-1:0] acc_y;
  logic signed [WORD_W-1:0] out_pos_x;
  logic signed [WORD_W-1:0] out_pos_y;
  logic signed [WORD_W-1:0] out_vel_x;
  logic signed [WORD_W-1:0] out_vel_y;

  modport source (output valid, acc_x, acc_y, out_pos_x, out_pos_y, out_vel_x,
                  out_vel_y, input ready);
  modport sink (input valid, acc_x, acc_y, out_pos_x, out_pos_y, out_vel_x,
                out_vel_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/gravity_euler_integrator.sv =====
// ----------------------------------------------------------------------------
// gravity_euler_integrator: point-mass gravity, semi-implicit Euler
// One body under gravity in fixed point; the multiplies, square root and
// divides run on one shared 128-bit add/subtract unit under a sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req       in   valid/ready    kind, pos_x/y, vel_in_x/y, body_mass, step_time
//  rsp       out  valid/ready    acc_x/y, out_pos_x/y, out_vel_x/y
//  cfg       in   cfg_wr_en      cfg_wr_data (grav_const)
//
//  Load item: goes straight to S_FIN, which writes the result once rsp is free.
//  Time step: four 32-step shift-add multiplies. Attractor: two 49-step
//  squares, a 49-step square root, a 32-step multiply and a 104-step divide,
//  then per nonzero axis an 81-step divide and a 33-step multiply.
//  req.ready is high only while idle; a result waiting on rsp does not block
//  the next item, only the write of the following result.
//  rst is synchronous; it clears the body state, sums and grav_const to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module gravity_euler_integrator
  import gei_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  gei_in_if.sink           req,
  gei_out_if.source        rsp,
  input  wire              cfg_wr_en,
  input  wire [WORD_W-1:0] cfg_wr_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_SQRT, S_KMUL, S_DIVM, S_SETX, S_CX, S_PX,
    S_SETY, S_CY, S_PY, S_DVX, S_DVY, S_DPX, S_DPY, S_FIN
  } state_t;

  state_t state;
  logic [6:0]   cnt;
  logic [127:0] acc, acc_next;
  logic [127:0] mcand, mcand_next;
  logic [48:0]  mplier;
  logic [103:0] quo, quo_next;
  logic [97:0]  dvs;
  logic [97:0]  s_reg;
  logic [48:0]  r_reg;
  logic [79:0]  mag_reg;
  logic [48:0]  ux, uy;
  logic         negx, negy;
  kind_t        kind_r;
  logic [MASS_W-1:0] mass_r;
  logic [TIME_W-1:0] dt_r;
  word_t ax, ay;
  word_t body_pos_x, body_pos_y, body_vel_x, body_vel_y;
  word_t accel_sum_x, accel_sum_y;
  logic [WORD_W-1:0] grav_const;

  // shared unit
  logic         sub_op;
  logic [127:0] sub_a, sub_b, res;
  logic         carry;

  logic signed [48:0] dx_c, dy_c;
  logic [48:0] ux_c, uy_c;
  logic [79:0] mag_cap;
  logic        acc_in, out_free;

  assign acc_in   = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  assign dx_c = 49'(req.pos_x) - 49'(body_pos_x);
  assign dy_c = 49'(req.pos_y) - 49'(body_pos_y);
  assign ux_c = dx_c[48] ? 49'(-dx_c) : 49'(dx_c);
  assign uy_c = dy_c[48] ? 49'(-dy_c) : 49'(dy_c);

  assign {carry, res} = {1'b0, sub_a} + {1'b0, (sub_op ? ~sub_b : sub_b)}
                        + {128'd0, sub_op};

  assign mag_cap = ((|quo_next[103:80]) || (quo_next[79] && (|quo_next[78:0])))
                   ? {1'b1, 79'd0} : quo_next[79:0];

  always_comb begin
    sub_op     = 1'b0;
    sub_a      = acc;
    sub_b      = mcand;
    acc_next   = acc;
    quo_next   = quo;
    mcand_next = mcand << 1;
    case (state)
      S_SQRT: begin
        sub_op     = 1'b1;
        sub_a      = {acc[125:0], mcand[127:126]};
        sub_b      = {22'd0, quo, 2'b01};
        mcand_next = mcand << 2;
        acc_next   = carry ? res : sub_a;
        quo_next   = {quo[102:0], carry};
      end
      S_DIVM, S_CX, S_CY: begin
        sub_op   = 1'b1;
        sub_a    = {acc[126:0], mcand[127]};
        sub_b    = {30'd0, dvs};
        acc_next = carry ? res : sub_a;
        quo_next = {quo[102:0], carry};
      end
      default: begin
        if (mplier[0]) acc_next = res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp.valid   <= 1'b0;
      grav_const  <= GRAV_RESET;
      body_pos_x  <= '0;
      body_pos_y  <= '0;
      body_vel_x  <= '0;
      body_vel_y  <= '0;
      accel_sum_x <= '0;
      accel_sum_y <= '0;
      cnt         <= '0;
    end else begin
      if (cfg_wr_en) grav_const <= cfg_wr_data;
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      if (state != S_IDLE && state != S_FIN) begin
        acc    <= acc_next;
        quo    <= quo_next;
        mcand  <= mcand_next;
        mplier <= mplier >> 1;
        cnt    <= cnt - 7'd1;
      end
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            kind_r <= req.kind;
            ax     <= '0;
            ay     <= '0;
            acc    <= '0;
            case (req.kind)
              KIND_LOAD: begin
                body_pos_x  <= req.pos_x;
                body_pos_y  <= req.pos_y;
                body_vel_x  <= req.vel_in_x;
                body_vel_y  <= req.vel_in_y;
                accel_sum_x <= '0;
                accel_sum_y <= '0;
                state       <= S_FIN;
              end
              KIND_ATTR: begin
                ux     <= ux_c;
                uy     <= uy_c;
                negx   <= dx_c[48];
                negy   <= dy_c[48];
                mass_r <= req.body_mass;
                mcand  <= {79'd0, ux_c};
                mplier <= ux_c;
                cnt    <= 7'd49;
                state  <= S_SQX;
              end
              KIND_STEP: begin
                dt_r   <= req.step_time;
                mcand  <= {80'd0, mag48(accel_sum_x)};
                mplier <= {17'd0, req.step_time};
                cnt    <= 7'd32;
                state  <= S_DVX;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_SQX: if (cnt == 7'd1) begin
          mcand  <= {79'd0, uy};
          mplier <= uy;
          cnt    <= 7'd49;
          state  <= S_SQY;
        end
        S_SQY: if (cnt == 7'd1) begin
          s_reg <= acc_next[97:0];
          if (acc_next[97:0] == '0) begin
            state <= S_FIN;
          end else begin
            acc   <= '0;
            quo   <= '0;
            mcand <= {acc_next[97:0], 30'd0};
            cnt   <= 7'd49;
            state <= S_SQRT;
          end
        end
        S_SQRT: if (cnt == 7'd1) begin
          r_reg  <= quo_next[48:0];
          acc    <= '0;
          mcand  <= {80'd0, grav_const};
          mplier <= {17'd0, mass_r};
          cnt    <= 7'd32;
          state  <= S_KMUL;
        end
        S_KMUL: if (cnt == 7'd1) begin
          acc   <= '0;
          quo   <= '0;
          mcand <= {acc_next[79:0], 48'd0};
          dvs   <= s_reg;
          cnt   <= 7'd104;
          state <= S_DIVM;
        end
        S_DIVM: if (cnt == 7'd1) begin
          mag_reg <= mag_cap;
          state   <= S_SETX;
        end
        S_SETX: begin
          if (ux == '0) begin
            state <= S_SETY;
          end else begin
            acc   <= '0;
            quo   <= '0;
            mcand <= {ux, 79'd0};
            dvs   <= {49'd0, r_reg};
            cnt   <= 7'd81;
            state <= S_CX;
          end
        end
        S_CX: if (cnt == 7'd1) begin
          acc    <= '0;
          mcand  <= {48'd0, mag_reg};
          mplier <= {16'd0, quo_next[32:0]};
          cnt    <= 7'd33;
          state  <= S_PX;
        end
        S_PX: if (cnt == 7'd1) begin
          ax    <= pull_sat(acc_next[112:32], negx);
          state <= S_SETY;
        end
        S_SETY: begin
          if (uy == '0) begin
            state <= S_FIN;
          end else begin
            acc   <= '0;
            quo   <= '0;
            mcand <= {uy, 79'd0};
            dvs   <= {49'd0, r_reg};
            cnt   <= 7'd81;
            state <= S_CY;
          end
        end
        S_CY: if (cnt == 7'd1) begin
          acc    <= '0;
          mcand  <= {48'd0, mag_reg};
          mplier <= {16'd0, quo_next[32:0]};
          cnt    <= 7'd33;
          state  <= S_PY;
        end
        S_PY: if (cnt == 7'd1) begin
          ay    <= pull_sat(acc_next[112:32], negy);
          state <= S_FIN;
        end
        S_DVX: if (cnt == 7'd1) begin
          body_vel_x <= add_sat(body_vel_x, {16'd0, acc_next[79:40]}, accel_sum_x[47]);
          acc        <= '0;
          mcand      <= {80'd0, mag48(accel_sum_y)};
          mplier     <= {17'd0, dt_r};
          cnt        <= 7'd32;
          state      <= S_DVY;
        end
        S_DVY: if (cnt == 7'd1) begin
          body_vel_y <= add_sat(body_vel_y, {16'd0, acc_next[79:40]}, accel_sum_y[47]);
          acc        <= '0;
          mcand      <= {80'd0, mag48(body_vel_x)};
          mplier     <= {17'd0, dt_r};
          cnt        <= 7'd32;
          state      <= S_DPX;
        end
        S_DPX: if (cnt == 7'd1) begin
          body_pos_x <= add_sat(body_pos_x, acc_next[79:24], body_vel_x[47]);
          acc        <= '0;
          mcand      <= {80'd0, mag48(body_vel_y)};
          mplier     <= {17'd0, dt_r};
          cnt        <= 7'd32;
          state      <= S_DPY;
        end
        S_DPY: if (cnt == 7'd1) begin
          body_pos_y  <= add_sat(body_pos_y, acc_next[79:24], body_vel_y[47]);
          accel_sum_x <= '0;
          accel_sum_y <= '0;
          state       <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            rsp.valid     <= 1'b1;
            rsp.acc_x     <= ax;
            rsp.acc_y     <= ay;
            rsp.out_pos_x <= body_pos_x;
            rsp.out_pos_y <= body_pos_y;
            rsp.out_vel_x <= body_vel_x;
            rsp.out_vel_y <= body_vel_y;
            if (kind_r == KIND_ATTR) begin
              accel_sum_x <= sat48(58'(accel_sum_x) + 58'(ax));
              accel_sum_y <= sat48(58'(accel_sum_y) + 58'(ay));
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    acc_in |=> state != S_IDLE)
    else $error("accepted item left the sequencer idle");

  a_result_written: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (rsp.valid && state == S_IDLE))
    else $error("finished item not written to output");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVM || state == S_CX || state == S_CY) |-> dvs != '0)
    else $error("divide started with zero divisor");

endmodule

`default_nettype wire

// ===== verif/gei_tb_if.sv =====
// ----------------------------------------------------------------------------
// gei_tb_if: testbench view of the integrator channels
// The block's own channel interfaces are used; this file holds the item
// and expectation records used by the test top.
// ----------------------------------------------------------------------------
`default_nettype none

package gei_tb_pkg;
  import gei_pkg::*;

  typedef struct packed {
    word_t acc_x;
    word_t acc_y;
    word_t pos_x;
    word_t pos_y;
    word_t vel_x;
    word_t vel_y;
  } body_report_t;

  typedef struct packed {
    kind_t               kind;
    logic signed [47:0]  pos_x;
    logic signed [47:0]  pos_y;
    logic signed [47:0]  vel_x;
    logic signed [47:0]  vel_y;
    logic [31:0]         mass;
    logic [31:0]         dt;
  } body_item_t;
endpackage

`default_nettype wire

// ===== verif/gravity_euler_integrator_test.sv =====
// ----------------------------------------------------------------------------
// gravity_euler_integrator_test: regression of the gravity Euler integrator
// Load, attractor, time step and reserved items go in with random gaps; each result
// is checked against a fixed-point model of the body kept in this bench.
// ----------------------------------------------------------------------------
`default_nettype none

module gravity_euler_integrator_test;
  import gei_pkg::*;
  import gei_tb_pkg::*;

  localparam logic signed [47:0] WMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] WMIN = 48'sh8000_0000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [47:0] cfg_wr_data = '0;

  gei_in_if  req ();
  gei_out_if rsp ();

  gravity_euler_integrator u_top (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // body model
  logic [47:0] g_const;
  logic signed [47:0] m_px, m_py, m_vx, m_vy, m_sx, m_sy;
  body_report_t pending_reports[$];
  int errors = 0;
  bit hold_rsp = 1'b0;
  bit quiet_rsp = 1'b0;

  function automatic logic signed [47:0] clamp(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF_FFFF) return WMAX;
    if (v < -128'sh8000_0000_0000) return WMIN;
    return v[47:0];
  endfunction

  // truncating signed product shift
  function automatic logic signed [127:0] scaled(input logic signed [47:0] a,
                                                input logic [31:0] b, input int sh);
    logic [127:0] m;
    logic [127:0] p;
    m = a < 0 ? 128'(-128'(a)) : 128'(a);
    p = (m * 128'(b)) >> sh;
    p = 128'(p[63:0]);
    return a < 0 ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic [63:0] root(input logic [127:0] s);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 48; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (128'(t) * 128'(t) <= s) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [47:0] axis_pull(input logic [63:0] u, input bit neg,
                                                   input logic [127:0] mag,
                                                   input logic [63:0] r);
    logic [127:0] c;
    logic [127:0] p;
    if (u == 0) return 0;
    c = 128'((({64'd0, u} << 32) / {64'd0, r}) & 128'hFFFF_FFFF_FFFF_FFFF);
    p = (mag * c) >> 32;
    if (neg) return (p >= (128'd1 << 47)) ? WMIN : -$signed(p[47:0]);
    return (p > 128'h7FFF_FFFF_FFFF) ? WMAX : p[47:0];
  endfunction

  function automatic body_report_t advance_body(input body_item_t it);
    body_report_t r;
    logic signed [63:0] dx, dy;
    logic [63:0] ux, uy, rr;
    logic [127:0] s, kk, mg;
    logic signed [47:0] ax, ay;
    ax = 0;
    ay = 0;
    case (it.kind)
      KIND_LOAD: begin
        m_px = it.pos_x; m_py = it.pos_y; m_vx = it.vel_x; m_vy = it.vel_y;
        m_sx = 0; m_sy = 0;
      end
      KIND_ATTR: begin
        dx = 64'(it.pos_x) - 64'(m_px);
        dy = 64'(it.pos_y) - 64'(m_py);
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        s = 128'(ux) * 128'(ux) + 128'(uy) * 128'(uy);
        if (s != 0) begin
          rr = root(s);
          kk = (128'(g_const) * 128'(it.mass)) << 24;
          mg = kk / s;
          if (mg > (128'd1 << 79)) mg = 128'd1 << 79;
          ax = axis_pull(ux, dx < 0, mg, rr);
          ay = axis_pull(uy, dy < 0, mg, rr);
        end
        m_sx = clamp(128'(m_sx) + 128'(ax));
        m_sy = clamp(128'(m_sy) + 128'(ay));
      end
      KIND_STEP: begin
        m_vx = clamp(128'(m_vx) + scaled(m_sx, it.dt, 40));
        m_vy = clamp(128'(m_vy) + scaled(m_sy, it.dt, 40));
        m_px = clamp(128'(m_px) + scaled(m_vx, it.dt, 24));
        m_py = clamp(128'(m_py) + scaled(m_vy, it.dt, 24));
        m_sx = 0; m_sy = 0;
      end
      default: ;
    endcase
    r.acc_x = ax; r.acc_y = ay;
    r.pos_x = m_px; r.pos_y = m_py; r.vel_x = m_vx; r.vel_y = m_vy;
    return r;
  endfunction

  task automatic wait_cycles(input int n);
    repeat (n) @(posedge clk);
  endtask

  // valid stays high across back-to-back items; drop it only for a gap
  task automatic send_item(input body_item_t it);
    int gap;
    gap = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 17)) : 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      wait_cycles(gap);
    end
    req.valid <= 1'b1;
    req.kind <= it.kind;
    req.pos_x <= it.pos_x;
    req.pos_y <= it.pos_y;
    req.vel_in_x <= it.vel_x;
    req.vel_in_y <= it.vel_y;
    req.body_mass <= it.mass;
    req.step_time <= it.dt;
    do @(posedge clk); while (!req.ready);
    pending_reports.push_back(advance_body(it));
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    wait_cycles(600);
  endtask

  task automatic write_grav(input logic [47:0] g);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= g;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    g_const = g;
  endtask

  function automatic logic signed [47:0] any_word();
    case ($urandom_range(0, 5))
      0: return WMAX;
      1: return WMIN;
      2: return 48'($signed($urandom_range(0, 4000)) - 2000) << 16;
      3: return 48'($signed($urandom_range(0, 200)) - 100) << 16;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic body_item_t make_item(input kind_t k);
    body_item_t it;
    it.kind = k;
    it.pos_x = any_word();
    it.pos_y = any_word();
    it.vel_x = any_word();
    it.vel_y = any_word();
    it.mass = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom;
    it.dt = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32'h0100_0000) : $urandom;
    return it;
  endfunction

  // checker
  always @(posedge clk) begin
    body_report_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_reports.size() == 0) begin
        $error("result with no expectation");
        errors++;
      end else begin
        e = pending_reports.pop_front();
        if (rsp.acc_x !== e.acc_x) begin
          $error("acc_x exp %h got %h", e.acc_x, rsp.acc_x); errors++; end
        if (rsp.acc_y !== e.acc_y) begin
          $error("acc_y exp %h got %h", e.acc_y, rsp.acc_y); errors++; end
        if (rsp.out_pos_x !== e.pos_x) begin
          $error("out_pos_x exp %h got %h", e.pos_x, rsp.out_pos_x); errors++; end
        if (rsp.out_pos_y !== e.pos_y) begin
          $error("out_pos_y exp %h got %h", e.pos_y, rsp.out_pos_y); errors++; end
        if (rsp.out_vel_x !== e.vel_x) begin
          $error("out_vel_x exp %h got %h", e.vel_x, rsp.out_vel_x); errors++; end
        if (rsp.out_vel_y !== e.vel_y) begin
          $error("out_vel_y exp %h got %h", e.vel_y, rsp.out_vel_y); errors++; end
      end
    end
  end

  // receiver stalls
  initial begin
    int gap;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        wait_cycles(2000);
        hold_rsp = 1'b0;
      end
      gap = quiet_rsp ? 0 : $urandom_range(0, 17) * ($urandom_range(0, 2) != 0);
      if (gap != 0) begin
        rsp.ready <= 1'b0;
        wait_cycles(gap);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic test_directed();
    body_item_t it;
    it = make_item(KIND_LOAD);
    it.pos_x = 0; it.pos_y = 0; it.vel_x = 0; it.vel_y = 0;
    send_item(it);
    // zero distance
    it.kind = KIND_ATTR; it.mass = 32'hFFFF_FFFF;
    send_item(it);
    it.pos_x = 48'sd1 <<< 16; it.mass = 32'd1000;
    send_item(it);
    it.pos_x = WMIN; it.pos_y = WMAX; it.mass = 32'hFFFF_FFFF;
    send_item(it);
    it.pos_x = 1; it.pos_y = -1; it.mass = 32'hFFFF_FFFF;
    send_item(it);
    it.pos_x = 0; it.pos_y = -(48'sd3 <<< 16); it.mass = 0;
    send_item(it);
    it.kind = KIND_STEP; it.dt = 32'hFFFF_FFFF;
    send_item(it);
    it.dt = 0;
    send_item(it);
    it.kind = KIND_LOAD; it.pos_x = WMAX; it.pos_y = WMIN;
    it.vel_x = WMAX; it.vel_y = WMIN;
    send_item(it);
    it.kind = KIND_STEP; it.dt = 32'hFFFF_FFFF;
    send_item(it);
    it.kind = KIND_ATTR; it.pos_x = WMIN; it.pos_y = WMAX; it.mass = 32'hFFFF_FFFF;
    send_item(it);
    // unused kind
    it.kind = KIND_RSVD;
    send_item(it);
    it.kind = KIND_STEP; it.dt = 32'h0100_0000;
    send_item(it);
    drain();
  endtask

  task automatic test_orbits(input int n);
    kind_t k;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1: k = KIND_LOAD;
        2, 3, 4, 5: k = KIND_ATTR;
        9: k = $urandom_range(0, 9) == 0 ? KIND_RSVD : KIND_STEP;
        default: k = KIND_STEP;
      endcase
      send_item(make_item(k));
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_rsp = 1'b1;
    repeat (12) send_item(make_item(KIND_STEP));
    drain();
    quiet_rsp = 1'b1;
    repeat (40) send_item(make_item(KIND_LOAD));
    quiet_rsp = 1'b0;
    drain();
  endtask

  initial begin
    req.valid <= 1'b0;
    req.kind <= KIND_LOAD;
    req.pos_x <= '0;
    req.pos_y <= '0;
    req.vel_in_x <= '0;
    req.vel_in_y <= '0;
    req.body_mass <= '0;
    req.step_time <= '0;
    g_const = GRAV_RESET;
    m_px = 0; m_py = 0; m_vx = 0; m_vy = 0; m_sx = 0; m_sy = 0;
    wait_cycles(9);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_orbits(300);
    write_grav(48'hFFFF_FFFF_FFFF);
    test_directed();
    test_orbits(200);
    write_grav('0);
    test_orbits(100);
    write_grav(48'({$urandom, $urandom}));
    test_orbits(200);
    test_backpressure();
    write_grav(GRAV_RESET);
    test_orbits(100);
    if (errors == 0) $display("gravity_euler_integrator regression: pass");
    else $display("gravity_euler_integrator regression: fail");
    $finish;
  end

  initial begin
    #40000000;
    $display("gravity_euler_integrator regression: fail");
    $finish;
  end
endmodule

`default_nettype wire
